@@ hdl/assert_macros.svh @@
// Assertion macros for the optical flow color coder checker.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication under reset
`define OFCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ofcc check failed");
// next-cycle implication under reset
`define OFCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ofcc check failed");
`endif

@@ hdl/ofcc_pkg.sv @@
// Shared constants, codes and tables for the optical flow color coder.
// No dependencies; used by the core and the CORDIC, and by the testbench.
package ofcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [32:0] PI_Q30 = 33'd3373259426;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [5:0] WHEEL_LAST = 6'd54;
    localparam logic [4:0] CORDIC_LAST = 5'd30;
    localparam logic [4:0] DIV_NORM_STEPS = 5'd30;
    localparam logic [4:0] DIV_POS_STEPS = 5'd22;
    localparam logic [23:0] BYTE_ONE = 24'hFF0000;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_COLOR = 2'd2;

    localparam logic [1:0] CH_RED = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE = 2'd2;

    localparam logic REG_MOTION_RANGE = 1'b0;
    localparam logic REG_UNKNOWN_THR = 1'b1;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] a;
        begin
            unique case (i)
                5'd0: a = 30'h3243F6A8;
                5'd1: a = 30'h1DAC6705;
                5'd2: a = 30'h0FADBAFC;
                5'd3: a = 30'h07F56EA6;
                5'd4: a = 30'h03FEAB76;
                5'd5: a = 30'h01FFD55B;
                5'd6: a = 30'h00FFFAAA;
                5'd7: a = 30'h007FFF55;
                5'd8: a = 30'h003FFFEA;
                5'd9: a = 30'h001FFFFD;
                5'd27: a = 30'h8;
                5'd28: a = 30'h4;
                5'd29: a = 30'h2;
                5'd30: a = 30'h1;
                default: a = (30'h1 << (5'd30 - i)) - 30'h1;
            endcase
            return a;
        end
    endfunction

    // segment ramps by reciprocal multiply: /15 -> *17, /6 -> 85/2, /11 and /13 in Q15
    function automatic logic [7:0] wheel_byte(input logic [5:0] k, input logic [1:0] ch);
        int unsigned i;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [7:0] v;
        begin
            i = 0;
            if (k < 6'd15) begin
                i = k; r = 255; g = 17 * i; b = 0;
            end else if (k < 6'd21) begin
                i = k - 15; r = 255 - ((85 * i) >> 1); g = 255; b = 0;
            end else if (k < 6'd25) begin
                i = k - 21; r = 0; g = 255; b = (255 * i) >> 2;
            end else if (k < 6'd36) begin
                i = k - 25; r = 0; g = 255 - ((255 * i * 2979) >> 15); b = 255;
            end else if (k < 6'd49) begin
                i = k - 36; r = (255 * i * 2521) >> 15; g = 0; b = 255;
            end else begin
                i = k - 49; r = 255; g = 0; b = 255 - ((85 * i) >> 1);
            end
            case (ch)
                CH_RED: v = 8'(r);
                CH_GREEN: v = 8'(g);
                default: v = 8'(b);
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/ofcc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the core.
module ofcc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] rem_init,
    input  logic [29:0] bits_in,
    input  logic [4:0]  steps,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [29:0] quotient
);

    logic [31:0] rem_reg;
    logic [29:0] sh_reg;
    logic [29:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, sh_reg[29]};
    assign fits = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            sh_reg <= bits_in;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            sh_reg <= {sh_reg[28:0], 1'b0};
            q_reg <= {q_reg[28:0], fits};
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/ofcc_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
// Used by the core for vector radius.
module ofcc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] bitv;
    logic [63:0] sum;
    logic        ge;

    assign bitv = 64'd1 << {cnt_reg, 1'b0};
    assign sum = res_reg + bitv;
    assign ge = n_reg >= sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= operand;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                n_reg <= n_reg - sum;
                res_reg <= (res_reg >> 1) + bitv;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

@@ hdl/ofcc_cordic.sv @@
// Vectoring CORDIC arctangent, one rotation per cycle.
// Uses ofcc_pkg for the angle table and pi.
module ofcc_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [34:0] x_in,
    input  logic signed [34:0] y_in,
    output logic               done,
    output logic signed [34:0] angle
);

    logic signed [34:0] x_reg;
    logic signed [34:0] y_reg;
    logic signed [34:0] z_reg;
    logic [4:0]         i_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [34:0] xs;
    logic signed [34:0] ys;
    logic signed [34:0] step_a;
    logic signed [34:0] pi_s;

    function automatic logic signed [34:0] shr0(input logic signed [34:0] v,
                                                input logic [4:0] s);
        logic signed [34:0] m;
        begin
            m = v[34] ? -v : v;
            m = m >>> s;
            return v[34] ? -m : m;
        end
    endfunction

    assign xs = shr0(x_reg, i_reg);
    assign ys = shr0(y_reg, i_reg);
    assign step_a = 35'(ofcc_pkg::atan_entry(i_reg));
    assign pi_s = 35'(ofcc_pkg::PI_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == ofcc_pkg::CORDIC_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in < 0)
            begin
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= (y_in >= 0) ? pi_s : -pi_s;
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_a;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_a;
            end
        end
    end

    assign done = done_reg;
    assign angle = z_reg;

endmodule

@@ hdl/optical_flow_color_coder_core.sv @@
// Optical flow color coder: one request in flight, one response per request.
// Clear, no-op and unknown vectors go straight to the response; measure squares both
// parts and takes a 32-step root; color runs two 30-step divides (a saturated part skips
// its divide), the root, a 31-step CORDIC, a 22-step wheel divide and channel mixing.
// Next request taken in the cycle after the response loads; a stalled response holds S_DONE.
// Reset (async, active low): running maximum 0, motion_range 0, threshold 0x7FFFFFFF.
module optical_flow_color_coder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] flow_u,
    input  logic signed [31:0] flow_v,
    input  logic               unknown_mark,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [31:0]        range_used,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DIVU = 12'b000000000010,
        S_DIVV = 12'b000000000100,
        S_SQ1  = 12'b000000001000,
        S_SQ2  = 12'b000000010000,
        S_SQRT = 12'b000000100000,
        S_CORD = 12'b000001000000,
        S_POSM = 12'b000010000000,
        S_POSD = 12'b000100000000,
        S_COLS = 12'b001000000000,
        S_COLM = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] motion_range_reg;
    logic [30:0] thr_reg;
    logic [31:0] max_reg;
    logic [1:0]  cmd_reg;
    logic        u_neg_reg;
    logic        v_neg_reg;
    logic [31:0] mu_reg;
    logic [31:0] mv_reg;
    logic [30:0] qu_reg;
    logic [30:0] qv_reg;
    logic [31:0] sq_a_reg;
    logic [63:0] acc_reg;
    logic [31:0] rad_reg;
    logic [32:0] t_reg;
    logic [37:0] t27_reg;
    logic [5:0]  k0_reg;
    logic [15:0] f_reg;
    logic [1:0]  ch_reg;
    logic [23:0] s_reg;
    logic [7:0]  r_reg;
    logic [7:0]  g_reg;
    logic [7:0]  b_reg;
    logic        go_reg;
    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [31:0] range_reg;

    logic        accept;
    logic        cfg_write;
    logic [31:0] eff_range;
    logic [31:0] in_mu;
    logic [31:0] in_mv;
    logic        in_unknown;
    logic        can_load;

    logic        div_start;
    logic [31:0] div_rem;
    logic [29:0] div_bits;
    logic [4:0]  div_steps;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [29:0] div_q;
    logic        sqrt_start;
    logic        sqrt_done;
    logic [31:0] sqrt_root;
    logic        cord_start;
    logic        cord_done;
    logic signed [34:0] cord_x;
    logic signed [34:0] cord_y;
    logic signed [34:0] cord_z;
    logic signed [35:0] t_sum;
    logic [5:0]  k1;
    logic [5:0]  pos_k;
    logic [16:0] f_inv;
    logic [23:0] s_mix;
    logic [23:0] s_diff;
    logic [55:0] s_prod;
    logic [23:0] s_dim;
    logic [25:0] s_trip;
    logic [7:0]  byte_val;
    logic        cur_big;
    logic [31:0] cur_mag;

    assign accept = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ofcc_pkg::REG_UNKNOWN_THR) ? {1'b0, thr_reg}
                                                           : motion_range_reg;

    assign eff_range = (motion_range_reg != 32'd0) ? motion_range_reg :
                       (max_reg != 32'd0) ? max_reg : (32'd1 << ofcc_pkg::FRAC_BITS);

    assign in_mu = flow_u[31] ? 32'(-flow_u) : flow_u;
    assign in_mv = flow_v[31] ? 32'(-flow_v) : flow_v;
    assign in_unknown = unknown_mark || (in_mu > {1'b0, thr_reg}) || (in_mv > {1'b0, thr_reg});

    assign cur_mag = (state_reg == S_DIVU) ? mu_reg : mv_reg;
    assign cur_big = cur_mag >= eff_range;

    assign div_start = ((state_reg == S_DIVU || state_reg == S_DIVV) && !go_reg && !cur_big) ||
                       (state_reg == S_POSD && !go_reg);
    assign div_rem = (state_reg == S_POSD) ? t27_reg[37:6] : cur_mag;
    assign div_bits = (state_reg == S_POSD) ? {t27_reg[5:0], 24'd0} : 30'd0;
    assign div_steps = (state_reg == S_POSD) ? ofcc_pkg::DIV_POS_STEPS
                                             : ofcc_pkg::DIV_NORM_STEPS;
    assign div_divisor = (state_reg == S_POSD) ? ofcc_pkg::PI_Q30[31:0] : eff_range;

    assign sqrt_start = (state_reg == S_SQRT) && !go_reg;
    assign cord_start = (state_reg == S_CORD) && !go_reg;
    assign cord_x = u_neg_reg ? 35'(qu_reg) : -35'(qu_reg);
    assign cord_y = v_neg_reg ? 35'(qv_reg) : -35'(qv_reg);

    assign t_sum = 36'(cord_z) + 36'(ofcc_pkg::PI_Q30);
    assign pos_k = (div_q[21:16] > ofcc_pkg::WHEEL_LAST) ? ofcc_pkg::WHEEL_LAST : div_q[21:16];
    assign k1 = (k0_reg == ofcc_pkg::WHEEL_LAST) ? 6'd0 : k0_reg + 6'd1;
    assign f_inv = 17'h10000 - 17'(f_reg);
    assign s_mix = 24'(25'(ofcc_pkg::wheel_byte(k0_reg, ch_reg)) * 25'(f_inv)
                 + 25'(ofcc_pkg::wheel_byte(k1, ch_reg)) * 25'(f_reg));
    assign s_diff = ofcc_pkg::BYTE_ONE - s_reg;
    assign s_prod = 56'(rad_reg) * 56'(s_diff);
    assign s_dim = ofcc_pkg::BYTE_ONE - s_prod[53:30];
    assign s_trip = 26'(s_reg) * 26'd3;
    assign byte_val = (rad_reg <= ofcc_pkg::ONE_Q30) ? s_dim[23:16] : s_trip[25:18];
    assign can_load = !out_valid_reg || !rsp_stall;

    ofcc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .rem_init(div_rem),
        .bits_in(div_bits), .steps(div_steps), .divisor(div_divisor),
        .done(div_done), .quotient(div_q)
    );

    ofcc_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start), .operand(acc_reg),
        .done(sqrt_done), .root(sqrt_root)
    );

    ofcc_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cord_start), .x_in(cord_x), .y_in(cord_y),
        .done(cord_done), .angle(cord_z)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == ofcc_pkg::CMD_MEASURE && !in_unknown)
                        state_next = S_SQ1;
                    else if (command == ofcc_pkg::CMD_COLOR && !in_unknown)
                        state_next = S_DIVU;
                    else
                        state_next = S_DONE;
                end
            end
            S_DIVU: if (cur_big || div_done) state_next = S_DIVV;
            S_DIVV: if (cur_big || div_done) state_next = S_SQ1;
            S_SQ1: state_next = S_SQ2;
            S_SQ2: state_next = S_SQRT;
            S_SQRT:
            begin
                if (sqrt_done)
                    state_next = (cmd_reg == ofcc_pkg::CMD_MEASURE) ? S_DONE : S_CORD;
            end
            S_CORD: if (cord_done) state_next = S_POSM;
            S_POSM: state_next = S_POSD;
            S_POSD: if (div_done) state_next = S_COLS;
            S_COLS: state_next = S_COLM;
            S_COLM: state_next = (ch_reg == ofcc_pkg::CH_BLUE) ? S_DONE : S_COLS;
            S_DONE: if (can_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            motion_range_reg <= '0;
            thr_reg <= 31'h7FFF_FFFF;
            max_reg <= '0;
            go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && paddr[2] == ofcc_pkg::REG_MOTION_RANGE)
                motion_range_reg <= pwdata;
            if (cfg_write && paddr[2] == ofcc_pkg::REG_UNKNOWN_THR)
                thr_reg <= pwdata[30:0];
            if (accept && command == ofcc_pkg::CMD_CLEAR)
                max_reg <= '0;
            if (state_reg == S_SQRT && sqrt_done && cmd_reg == ofcc_pkg::CMD_MEASURE
                && sqrt_root > max_reg)
                max_reg <= sqrt_root;
            if (div_start || sqrt_start || cord_start)
                go_reg <= 1'b1;
            else if (div_done || sqrt_done || cord_done)
                go_reg <= 1'b0;
            if (state_reg == S_DONE && can_load)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            u_neg_reg <= flow_u[31];
            v_neg_reg <= flow_v[31];
            mu_reg <= in_mu;
            mv_reg <= in_mv;
            sq_a_reg <= in_mu;
            r_reg <= '0;
            g_reg <= '0;
            b_reg <= '0;
        end
        if (state_reg == S_DIVU && (cur_big || div_done))
            qu_reg <= cur_big ? 31'(ofcc_pkg::ONE_Q30) : 31'(div_q);
        if (state_reg == S_DIVV && (cur_big || div_done))
        begin
            qv_reg <= cur_big ? 31'(ofcc_pkg::ONE_Q30) : 31'(div_q);
            sq_a_reg <= 32'(qu_reg);
        end
        if (state_reg == S_SQ1)
        begin
            acc_reg <= 64'(sq_a_reg) * 64'(sq_a_reg);
            sq_a_reg <= (cmd_reg == ofcc_pkg::CMD_MEASURE) ? mv_reg : 32'(qv_reg);
        end
        if (state_reg == S_SQ2)
            acc_reg <= acc_reg + 64'(sq_a_reg) * 64'(sq_a_reg);
        if (state_reg == S_SQRT && sqrt_done)
            rad_reg <= sqrt_root;
        if (state_reg == S_CORD && cord_done)
        begin
            if (t_sum < 0)
                t_reg <= '0;
            else if (t_sum > 36'(ofcc_pkg::TWO_PI_Q30))
                t_reg <= ofcc_pkg::TWO_PI_Q30;
            else
                t_reg <= t_sum[32:0];
        end
        if (state_reg == S_POSM)
            t27_reg <= 38'(t_reg) * 38'd27;
        if (state_reg == S_POSD && div_done)
        begin
            k0_reg <= pos_k;
            f_reg <= div_q[15:0];
            ch_reg <= ofcc_pkg::CH_RED;
        end
        if (state_reg == S_COLS)
            s_reg <= s_mix;
        if (state_reg == S_COLM)
        begin
            case (ch_reg)
                ofcc_pkg::CH_RED: r_reg <= byte_val;
                ofcc_pkg::CH_GREEN: g_reg <= byte_val;
                default: b_reg <= byte_val;
            endcase
            ch_reg <= ch_reg + 2'd1;
        end
        if (state_reg == S_DONE && can_load)
        begin
            red_reg <= r_reg;
            green_reg <= g_reg;
            blue_reg <= b_reg;
            range_reg <= eff_range;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign range_used = range_reg;

endmodule

@@ hdl/ofcc_checker.sv @@
// Port-level checker for the optical flow color coder core, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ofcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] range_used,
    input logic        pready
);

    `OFCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    `OFCC_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)
    `OFCC_ASSERT_NOW(a_range_nonzero, rsp_valid, range_used != 32'd0)
    `OFCC_ASSERT_NOW(a_apb_ready, 1'b1, pready)

endmodule

bind optical_flow_color_coder_core ofcc_checker u_ofcc_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .range_used(range_used),
    .pready(pready)
);

@@ test/ofcc_checker.sv @@
// Checker for the optical flow color coder: tracks register writes, predicts each response.
// Depends on ofcc_pkg for command codes, register indexes and pi in Q30.
module ofcc_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] flow_u,
    input  logic signed [31:0] flow_v,
    input  logic               unknown_mark,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [31:0]        range_used,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] range_used;
    } pixel_color_t;

    localparam longint PI_FIX = longint'(ofcc_pkg::PI_Q30);
    localparam longint ONE_FIX = 64'sd1 << 30;
    localparam longint ARCTAN_Q30 [31] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001
    };

    logic [31:0] fixed_range;
    logic [30:0] unknown_limit;
    logic [31:0] peak_radius;
    pixel_color_t pending_colors[$];

    assign outstanding = pending_colors.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint shift_to_zero(longint x, int s);
        if (x < 0)
            return -longint'(longint'(-x) >>> s);
        return x >>> s;
    endfunction

    function automatic longint scale_q30(longint x, longint unsigned span);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? longint'(-x) : x;
        q = (mag >= span) ? longint'(ONE_FIX) : (mag << 30) / span;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint heading_q30(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_FIX : -PI_FIX;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 31; i++)
        begin
            xs = shift_to_zero(x, i);
            ys = shift_to_zero(y, i);
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += ARCTAN_Q30[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= ARCTAN_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic int unsigned hue_byte(int unsigned k, int ch);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        if (k < 15)
        begin
            r = 255; g = 255 * k / 15; b = 0;
        end
        else if (k < 21)
        begin
            r = 255 - 255 * (k - 15) / 6; g = 255; b = 0;
        end
        else if (k < 25)
        begin
            r = 0; g = 255; b = 255 * (k - 21) / 4;
        end
        else if (k < 36)
        begin
            r = 0; g = 255 - 255 * (k - 25) / 11; b = 255;
        end
        else if (k < 49)
        begin
            r = 255 * (k - 36) / 13; g = 0; b = 255;
        end
        else
        begin
            r = 255; g = 0; b = 255 - 255 * (k - 49) / 6;
        end
        return (ch == 0) ? r : ((ch == 1) ? g : b);
    endfunction

    function automatic logic [31:0] active_range();
        if (fixed_range != 0)
            return fixed_range;
        if (peak_radius != 0)
            return peak_radius;
        return 32'd1 << ofcc_pkg::FRAC_BITS;
    endfunction

    function automatic pixel_color_t color_pixel(logic [1:0] cmd, logic signed [31:0] u_in,
                                                 logic signed [31:0] v_in, logic mark);
        pixel_color_t res;
        longint u;
        longint v;
        longint unsigned mu;
        longint unsigned mv;
        longint unsigned span;
        longint unsigned rad;
        longint unsigned pos;
        longint unsigned frac;
        longint unsigned mix;
        longint unsigned one;
        longint du;
        longint dv;
        longint t;
        int unsigned k0;
        int unsigned k1;
        int unsigned chan [3];
        logic unknown;
        u = u_in;
        v = v_in;
        mu = (u < 0) ? longint'(-u) : u;
        mv = (v < 0) ? longint'(-v) : v;
        unknown = mark || mu > unknown_limit || mv > unknown_limit;
        chan = '{0, 0, 0};
        one = 64'd255 << 16;
        if (cmd == ofcc_pkg::CMD_CLEAR)
            peak_radius = 0;
        else if (cmd == ofcc_pkg::CMD_MEASURE)
        begin
            if (!unknown)
            begin
                rad = int_sqrt(mu * mu + mv * mv);
                if (rad > peak_radius)
                    peak_radius = rad[31:0];
            end
        end
        else if (cmd == ofcc_pkg::CMD_COLOR && !unknown)
        begin
            span = active_range();
            du = scale_q30(u, span);
            dv = scale_q30(v, span);
            rad = int_sqrt(longint'(du * du) + longint'(dv * dv));
            t = heading_q30(-dv, -du) + PI_FIX;
            if (t < 0)
                t = 0;
            if (t > 2 * PI_FIX)
                t = 2 * PI_FIX;
            pos = ((longint'(t) * 27) << 16) / longint'(PI_FIX);
            k0 = 32'(pos >> 16);
            if (k0 > 54)
                k0 = 54;
            frac = pos & 64'hFFFF;
            k1 = (k0 == 54) ? 0 : k0 + 1;
            for (int c = 0; c < 3; c++)
            begin
                mix = hue_byte(k0, c) * (65536 - frac) + hue_byte(k1, c) * frac;
                if (rad <= ONE_FIX)
                    chan[c] = 32'((one - ((rad * (one - mix)) >> 30)) >> 16);
                else
                    chan[c] = 32'((3 * mix) >> 18);
                if (chan[c] > 255)
                    chan[c] = 255;
            end
        end
        res.red = chan[0][7:0];
        res.green = chan[1][7:0];
        res.blue = chan[2][7:0];
        res.range_used = active_range();
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_color_t want;
        pixel_color_t got;
        if (!rst_n)
        begin
            fixed_range <= '0;
            unknown_limit <= 31'h7FFF_FFFF;
            peak_radius = '0;
            errors <= 0;
            pending_colors.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {ofcc_pkg::REG_MOTION_RANGE, 2'b00})
                    fixed_range <= pwdata;
                else if (paddr == {ofcc_pkg::REG_UNKNOWN_THR, 2'b00})
                    unknown_limit <= pwdata[30:0];
            end
            if (req_valid && !req_stall)
                pending_colors.push_back(color_pixel(command, flow_u, flow_v, unknown_mark));
            if (rsp_valid && !rsp_stall)
            begin
                got = '{red, green, blue, range_used};
                if (pending_colors.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected response %p", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (want !== got)
                    begin
                        if (errors < 10)
                            $display("response differs: expected %p, got %p", want, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/tb.sv @@
// Top of the optical flow color coder testbench: clock, reset, register writes, requests.
// Depends on ofcc_pkg, optical_flow_color_coder_core and ofcc_scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [2:0] ADDR_RANGE = {ofcc_pkg::REG_MOTION_RANGE, 2'b00};
    localparam logic [2:0] ADDR_LIMIT = {ofcc_pkg::REG_UNKNOWN_THR, 2'b00};
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [1:0] command = ofcc_pkg::CMD_CLEAR;
    logic signed [31:0] flow_u = '0;
    logic signed [31:0] flow_v = '0;
    logic unknown_mark = 1'b0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [31:0] range_used;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int errors;
    int outstanding;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    optical_flow_color_coder_core dut (.*);

    ofcc_scoreboard checker_i (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        rsp_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("optical_flow_color_coder_core: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_request(logic [1:0] cmd, logic [31:0] u, logic [31:0] v, logic mark);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        command <= cmd;
        flow_u <= u;
        flow_v <= v;
        unknown_mark <= mark;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] random_flow();
        logic [31:0] mag;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        mag = $urandom >> $urandom_range(4, 31);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [1:0] random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return ofcc_pkg::CMD_COLOR;
        if (pick < 88)
            return ofcc_pkg::CMD_MEASURE;
        if (pick < 95)
            return ofcc_pkg::CMD_CLEAR;
        return CMD_NOP;
    endfunction

    initial
    begin
        logic [31:0] ranges [8];
        logic [31:0] limits [8];
        ranges = '{32'h0, 32'hFFFF_FFFF, 32'h1, $urandom, 32'h10000, 32'h0,
                   $urandom >> 8, 32'h0};
        limits = '{32'h7FFF_FFFF, 32'h0, $urandom >> 1, 32'h10000, 32'h7FFF_FFFF,
                   $urandom >> $urandom_range(1, 20), 32'h7FFF_FFFF, 32'h7FFF_0000};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(ADDR_RANGE, 32'h0);
        write_reg(ADDR_LIMIT, 32'h7FFF_FFFF);
        send_request(ofcc_pkg::CMD_CLEAR, 32'h0, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h0, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h10000, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_MEASURE, 32'h30000, 32'h40000, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h50000, 32'h50000, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, -32'sh50000, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h0, -32'sh50000, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h0, 32'h50000, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, -32'sh20000, -32'sh10000, 1'b0);
        send_request(ofcc_pkg::CMD_MEASURE, 32'h8000_0000, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_MEASURE, 32'h1000_0000, 32'h0, 1'b1);
        send_request(ofcc_pkg::CMD_COLOR, 32'h10000, 32'h10000, 1'b1);
        send_request(ofcc_pkg::CMD_COLOR, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(CMD_NOP, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
        send_request(ofcc_pkg::CMD_COLOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(ofcc_pkg::CMD_MEASURE, 32'h7FFF_FFFF, -32'sh7FFF_FFFF, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h1, -32'sh1, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, -32'sh7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(ofcc_pkg::CMD_CLEAR, 32'h0, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, -32'sh1, 32'h0, 1'b0);
        drain();
        write_reg(ADDR_LIMIT, 32'h0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h1, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_COLOR, 32'h0, 32'h0, 1'b0);
        send_request(ofcc_pkg::CMD_MEASURE, 32'h0, -32'sh1, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 50; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 50; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            write_reg(ADDR_RANGE, ranges[ph]);
            write_reg(ADDR_LIMIT, limits[ph]);
            for (int n = 0; n < 172; n++)
                send_request(random_command(), random_flow(), random_flow(),
                             $urandom_range(0, 9) == 0);
            drain();
        end

        stall_pct = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("optical_flow_color_coder_core: match");
        else
            $display("optical_flow_color_coder_core: mismatch");
        $finish;
    end
endmodule
